/* hdl/itp_pkg.sv */
// ----------------------------------------------------------------------------
// Integer text parser package
// Shared types, character codes and helpers for the text-to-integer parser.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int MaxLen   = 4096;
  localparam int PosW     = $clog2(MaxLen + 1);
  localparam int ValueW   = 64;
  localparam int BaseW    = 6;
  localparam int EndW     = 13;
  localparam int CharW    = 8;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegRadix  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegSigned = 1'd1;

  // Character codes.
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0d;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5a;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7a;

  // Bases.
  localparam logic [BaseW-1:0] BaseAuto = 6'd0;
  localparam logic [BaseW-1:0] Base8    = 6'd8;
  localparam logic [BaseW-1:0] Base10   = 6'd10;
  localparam logic [BaseW-1:0] Base16   = 6'd16;

  typedef enum logic [2:0] {
    PH_WS,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              negative;
    logic              any_digits;
    logic [EndW-1:0]   end_index;
    logic [BaseW-1:0]  base_used;
  } result_t;

  typedef struct packed {
    logic             ok;
    logic [BaseW-1:0] val;
  } digit_t;

  function automatic digit_t digit_of(input logic [CharW-1:0] c);
    digit_t d;
    d.ok  = 1'b0;
    d.val = '0;
    if (c >= ChZero && c <= ChNine) begin
      d.ok  = 1'b1;
      d.val = BaseW'(c - ChZero);
    end else if (c >= ChLowA && c <= ChLowZ) begin
      d.ok  = 1'b1;
      d.val = BaseW'(c - ChLowA) + Base10;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      d.ok  = 1'b1;
      d.val = BaseW'(c - ChUpA) + Base10;
    end
    return d;
  endfunction

endpackage

/* hdl/itp_core.sv */
// ----------------------------------------------------------------------------
// Integer text parser core
// Per-string parse state and the one-character step: whitespace, sign,
// prefix detection and the multiply-add accumulation.
// ----------------------------------------------------------------------------
module itp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [itp_pkg::CharW-1:0]     ch_i,
  input  logic [itp_pkg::BaseW-1:0]     radix_i,
  input  logic                          signed_mode_i,
  output logic                          emit_o,
  output itp_pkg::result_t              result_o
);

  itp_pkg::phase_e                 phase_q, phase_d;
  logic [itp_pkg::ValueW-1:0]      acc_q, acc_d;
  logic                            minus_q, minus_d;
  logic                            dseen_q, dseen_d;
  logic [itp_pkg::BaseW-1:0]       base_q, base_d;
  logic [itp_pkg::PosW-1:0]        pos_q, pos_d;

  logic                            is_blank, is_sign, is_x, is_nul;
  logic                            zero_prefix;
  logic                            take_path, digit_ok;
  logic [itp_pkg::BaseW-1:0]       eff_base, start_base;
  logic                            eff_dseen;
  itp_pkg::digit_t                 dig;
  logic [itp_pkg::ValueW-1:0]      acc_mul, acc_new, val_raw;
  logic [itp_pkg::PosW-1:0]        pos_inc;

  assign is_nul   = (ch_i == itp_pkg::ChNul);
  assign is_blank = (ch_i == itp_pkg::ChSpace) ||
                    (ch_i >= itp_pkg::ChTab && ch_i <= itp_pkg::ChCr);
  assign is_sign  = (ch_i == itp_pkg::ChMinus) || (ch_i == itp_pkg::ChPlus);
  assign is_x     = (ch_i == itp_pkg::ChLowX) || (ch_i == itp_pkg::ChUpX);

  // A leading zero opens a prefix only in auto and hexadecimal mode.
  assign zero_prefix = ((radix_i == itp_pkg::BaseAuto) || (radix_i == itp_pkg::Base16)) &&
                       (ch_i == itp_pkg::ChZero);
  assign start_base  = (radix_i == itp_pkg::BaseAuto) ? itp_pkg::Base10 : radix_i;

  assign take_path = ((phase_q == itp_pkg::PH_WS) && !is_blank && !is_sign && !zero_prefix) ||
                     ((phase_q == itp_pkg::PH_PREFIX) && !zero_prefix) ||
                     ((phase_q == itp_pkg::PH_ZERO) && !is_x) ||
                     (phase_q == itp_pkg::PH_DIGITS);

  // The base latches at the first character after whitespace and sign.
  assign eff_base  = ((phase_q == itp_pkg::PH_WS) || (phase_q == itp_pkg::PH_PREFIX)) ?
                     start_base : base_q;
  // A lone zero counts as a digit once it is known not to start 0x.
  assign eff_dseen = (phase_q == itp_pkg::PH_ZERO) ? 1'b1 : dseen_q;

  assign dig      = itp_pkg::digit_of(ch_i);
  assign digit_ok = dig.ok && !is_nul && (dig.val < eff_base);
  assign emit_o   = take_path && !digit_ok;

  assign acc_mul = acc_q * itp_pkg::ValueW'(eff_base);
  assign acc_new = acc_mul + itp_pkg::ValueW'(dig.val);
  assign pos_inc = (pos_q < itp_pkg::PosW'(itp_pkg::MaxLen)) ? pos_q + 1'b1 : pos_q;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      itp_pkg::PH_WS: begin
        if (is_blank) begin
          phase_d = itp_pkg::PH_WS;
        end else if (is_sign) begin
          phase_d = itp_pkg::PH_PREFIX;
        end else if (zero_prefix) begin
          phase_d = itp_pkg::PH_ZERO;
        end
      end
      itp_pkg::PH_PREFIX: begin
        if (zero_prefix) begin
          phase_d = itp_pkg::PH_ZERO;
        end
      end
      itp_pkg::PH_ZERO: begin
        if (is_x) begin
          phase_d = itp_pkg::PH_DIGITS;
        end
      end
      itp_pkg::PH_DIGITS: begin
        phase_d = itp_pkg::PH_DIGITS;
      end
      default: begin
        if (is_nul) begin
          phase_d = itp_pkg::PH_WS;
        end
      end
    endcase
    if (take_path) begin
      if (digit_ok) begin
        phase_d = itp_pkg::PH_DIGITS;
      end else if (is_nul) begin
        phase_d = itp_pkg::PH_WS;
      end else begin
        phase_d = itp_pkg::PH_DONE;
      end
    end
  end

  // Datapath and result.
  always_comb begin
    acc_d   = acc_q;
    minus_d = minus_q;
    dseen_d = dseen_q;
    base_d  = base_q;
    pos_d   = pos_q;
    case (phase_q)
      itp_pkg::PH_WS: begin
        if (is_blank) begin
          pos_d = pos_inc;
        end else if (is_sign) begin
          minus_d = (ch_i == itp_pkg::ChMinus);
          pos_d   = pos_inc;
        end else if (zero_prefix) begin
          base_d = (radix_i == itp_pkg::BaseAuto) ? itp_pkg::Base8 : itp_pkg::Base16;
          pos_d  = pos_inc;
        end
      end
      itp_pkg::PH_PREFIX: begin
        if (zero_prefix) begin
          base_d = (radix_i == itp_pkg::BaseAuto) ? itp_pkg::Base8 : itp_pkg::Base16;
          pos_d  = pos_inc;
        end
      end
      itp_pkg::PH_ZERO: begin
        if (is_x) begin
          base_d = itp_pkg::Base16;
          pos_d  = pos_inc;
        end
      end
      default: begin
      end
    endcase
    if (take_path) begin
      base_d  = eff_base;
      dseen_d = eff_dseen;
      if (digit_ok) begin
        acc_d   = acc_new;
        dseen_d = 1'b1;
        pos_d   = pos_inc;
      end
    end
    // The terminator always starts a fresh string.
    if ((take_path && !digit_ok && is_nul) ||
        (!take_path && is_nul && (phase_q != itp_pkg::PH_WS) &&
         (phase_q != itp_pkg::PH_PREFIX) && (phase_q != itp_pkg::PH_ZERO))) begin
      acc_d   = '0;
      minus_d = 1'b0;
      dseen_d = 1'b0;
      base_d  = '0;
      pos_d   = '0;
    end

    val_raw             = eff_dseen ? acc_q : '0;
    result_o.value      = (signed_mode_i && minus_q) ? (~val_raw + 1'b1) : val_raw;
    result_o.negative   = minus_q;
    result_o.any_digits = eff_dseen;
    result_o.end_index  = eff_dseen ? itp_pkg::EndW'(pos_q) : '0;
    result_o.base_used  = eff_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= itp_pkg::PH_WS;
      acc_q   <= '0;
      minus_q <= 1'b0;
      dseen_q <= 1'b0;
      base_q  <= '0;
      pos_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      minus_q <= minus_d;
      dseen_q <= dseen_d;
      base_q  <= base_d;
      pos_q   <= pos_d;
    end
  end

endmodule

/* hdl/itp_out_reg.sv */
// ----------------------------------------------------------------------------
// Integer text parser result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module itp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  itp_pkg::result_t  result_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output itp_pkg::result_t  result_o
);

  logic             vld_q, vld_d;
  itp_pkg::result_t res_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

/* hdl/integer_text_parser.sv */
// ----------------------------------------------------------------------------
// Integer text parser
// Streams a zero-terminated string and returns its integer value.
// ----------------------------------------------------------------------------
// Usage: send the string one character per word on the input channel
// (in_valid_i / in_ready_o, ch_i), ending with a zero byte. Leading
// whitespace and one sign are skipped, the base is picked from radix or
// from the prefix, and at the first non-digit or the terminator one result
// word leaves on the output channel (out_valid_o / out_ready_i). Characters
// after the result are dropped up to and including the terminator.
// Configuration words go in on cfg_valid_i / cfg_ready_o with cfg_index_i
// (0 radix, 1 signed mode) and cfg_data_i; they are always accepted.
// An ending character is registered in the character stage and its result
// in the result register. Throughput: one character per cycle unless the
// receiver stalls, set by the single multiply-add of the accumulator loop.
// Reset clears the parse state, the registers and both channel stages.
// When the receiver stalls with a result pending, the character stage holds
// and the input stalls one word later.
// ----------------------------------------------------------------------------
module integer_text_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [itp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [itp_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [itp_pkg::CharW-1:0]       ch_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [itp_pkg::ValueW-1:0]      value_o,
  output logic                            negative_o,
  output logic                            any_digits_o,
  output logic [itp_pkg::EndW-1:0]        end_index_o,
  output logic [itp_pkg::BaseW-1:0]       base_used_o
);

  logic [itp_pkg::BaseW-1:0]  radix_q;
  logic                       signed_q;
  logic                       ch_vld_q;
  logic [itp_pkg::CharW-1:0]  ch_q;
  logic                       step, emit;
  itp_pkg::result_t           core_res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= '0;
      signed_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        itp_pkg::RegRadix:  radix_q  <= cfg_data_i[itp_pkg::BaseW-1:0];
        itp_pkg::RegSigned: signed_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Character stage; it moves on whenever the result register can take a word.
  assign step       = ch_vld_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !ch_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      ch_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q <= ch_i;
    end
  end

  itp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .ch_i          (ch_q),
    .radix_i       (radix_q),
    .signed_mode_i (signed_q),
    .emit_o        (emit),
    .result_o      (core_res)
  );

  itp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && emit),
    .result_i    (core_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .result_o    (out_res)
  );

  assign value_o      = out_res.value;
  assign negative_o   = out_res.negative;
  assign any_digits_o = out_res.any_digits;
  assign end_index_o  = out_res.end_index;
  assign base_used_o  = out_res.base_used;

endmodule

/* hdl/itp_checker.sv */
// ----------------------------------------------------------------------------
// Integer text parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module itp_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic [itp_pkg::ValueW-1:0]      value_o,
  input  logic                            negative_o,
  input  logic                            any_digits_o,
  input  logic [itp_pkg::EndW-1:0]        end_index_o,
  input  logic [itp_pkg::BaseW-1:0]       base_used_o
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) &&
    $stable(negative_o) && $stable(any_digits_o) &&
    $stable(end_index_o) && $stable(base_used_o))
    else $error("result word changed while stalled");

  // The end offset never passes the length limit.
  a_end_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> end_index_o <= itp_pkg::EndW'(itp_pkg::MaxLen))
    else $error("end offset beyond length limit");

  // Without digits the value and the end offset are both zero.
  a_no_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !any_digits_o |-> (value_o == '0) && (end_index_o == '0))
    else $error("result without digits is not zero");

  // A digit always moves the end offset past the start of the string.
  a_digits_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && any_digits_o |-> end_index_o != '0)
    else $error("result with digits has zero end offset");

endmodule

bind integer_text_parser itp_checker u_itp_checker (.*);
